FILE: rtl/array_linked_list_free_list_defines.svh
// Assertion helpers for the linked list control module.
`ifndef ARRAY_LINKED_LIST_FREE_LIST_DEFINES_SVH
`define ARRAY_LINKED_LIST_FREE_LIST_DEFINES_SVH

`define ALLFL_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ALLFL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define ALLFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/allfl_pkg.sv
`timescale 1ns / 1ps
package allfl_pkg;

   localparam int LIST_SLOTS = 16;
   localparam int DATA_WIDTH = 32;
   localparam int SLOT_W     = $clog2(LIST_SLOTS);
   localparam int LINK_W     = $clog2(LIST_SLOTS + 1);
   localparam int POS_W      = 4;
   localparam int STATUS_W   = 2;

   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(LIST_SLOTS);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_SUCC = 2'd3;

   typedef struct packed {
      logic                load;
      logic                rd_first;
      logic                rd_second;
      logic                wr_first;
      logic                wr_second;
      logic                emit;
      logic [STATUS_W-1:0] status;
   } cmd_type;

   typedef struct packed {
      logic op_insert;
      logic at_head;
      logic free_null;
      logic list_null;
      logic succ_null;
      logic out_free;
   } sts_type;

   // link value of a slot that was never written: the next slot, null after the last
   function automatic logic [LINK_W-1:0] reset_link(input logic [SLOT_W-1:0] slot);
      return LINK_W'(slot) + LINK_W'(1);
   endfunction

endpackage

FILE: rtl/array_linked_list_free_list.sv
`timescale 1ns / 1ps
// Linked list of 16 slots with a free list, both chained through one link store.
// req channel: one request per handshake, an insert (takes the free-list head,
//   stores the word, links it at the list head or after slot_pos) or a delete
//   (unlinks the list head or the successor of slot_pos and frees that slot).
// rsp channel: exactly one result per request, in request order, carrying the
//   status code, the removed word, the slot used and the empty/full flags.
// Steps: accept, check with the first link read, second link read (delete after
//   a slot), first link write, second link write (insert or delete after a
//   slot), result. A pool-full or list-empty request goes from the check to
//   the result, a missing successor from the second read. One request is worked
//   at a time; the next is accepted the cycle after its result is loaded.
//   The steps are set by the single write port of the link store: an operation
//   after a slot changes two links, and a delete after a slot also reads links
//   twice in sequence.
// Reset: the list is empty and every slot is free in order 0..15; no memory
//   clearing pass is needed.
// Stall: a result waits in the output register; the block finishes the next
//   request and then holds it until the output register is taken.
module array_linked_list_free_list (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [allfl_pkg::REQ_DATA_W-1:0]   req_tdata,  // slot_pos[3:0], value_in[35:4]
   input  logic [allfl_pkg::REQ_USER_W-1:0]   req_tuser,  // opcode[0], at_head[1]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [allfl_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // value_out[31:0], slot_used[35:32],
                                                          // now_empty[36], now_full[37]
   output logic [allfl_pkg::RSP_USER_W-1:0]   rsp_tuser   // status[1:0]
);

   allfl_pkg::cmd_type cmd;
   allfl_pkg::sts_type sts;

   allfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   allfl_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: rtl/allfl_ctrl.sv
`timescale 1ns / 1ps
`include "array_linked_list_free_list_defines.svh"
module allfl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  allfl_pkg::sts_type  sts,
   output allfl_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_READ2  = 3'd2;
   localparam logic [2:0] S_WRITE1 = 3'd3;
   localparam logic [2:0] S_WRITE2 = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [allfl_pkg::STATUS_W-1:0] status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= allfl_pkg::ST_DONE;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      cmd       = '0;
      cmd.status = status_ff;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (sts.op_insert && sts.free_null) begin
               status_in = allfl_pkg::ST_FULL;
               state_in  = S_RESP;
            end else if (!sts.op_insert && sts.list_null) begin
               status_in = allfl_pkg::ST_EMPTY;
               state_in  = S_RESP;
            end else begin
               cmd.rd_first = 1'b1;
               status_in    = allfl_pkg::ST_DONE;
               state_in     = (!sts.op_insert && !sts.at_head) ? S_READ2 : S_WRITE1;
            end
         end
         S_READ2: begin
            if (sts.succ_null) begin
               status_in = allfl_pkg::ST_NO_SUCC;
               state_in  = S_RESP;
            end else begin
               cmd.rd_second = 1'b1;
               state_in      = S_WRITE1;
            end
         end
         S_WRITE1: begin
            cmd.wr_first = 1'b1;
            state_in     = sts.at_head ? S_RESP : S_WRITE2;
         end
         S_WRITE2: begin
            cmd.wr_second = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `ALLFL_ASSERT_ALWAYS(a_one_cmd, clock, reset, $onehot0({cmd.load, cmd.rd_first, cmd.rd_second, cmd.wr_first, cmd.wr_second, cmd.emit}), "more than one datapath command")
   `ALLFL_ASSERT_NEXT(a_accept_read, clock, reset, req_valid && req_ready, state_ff == S_READ, "accepted request not checked next")
   `ALLFL_ASSERT_IMPLY(a_write2_order, clock, reset, state_ff == S_WRITE2, $past(state_ff) == S_WRITE1, "second link write without first")

endmodule

FILE: rtl/allfl_dpath.sv
`timescale 1ns / 1ps
module allfl_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  allfl_pkg::cmd_type                   cmd,
   output allfl_pkg::sts_type                   sts,
   input  logic [allfl_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [allfl_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [allfl_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [allfl_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   localparam int SW = allfl_pkg::SLOT_W;
   localparam int LW = allfl_pkg::LINK_W;
   localparam int DW = allfl_pkg::DATA_WIDTH;
   localparam int NS = allfl_pkg::LIST_SLOTS;

   // latched request
   logic          op_ff, at_head_ff;
   logic [SW-1:0] pos_ff;
   logic [DW-1:0] val_ff;

   // chain heads
   logic [LW-1:0] list_head_ff, list_head_in;
   logic [LW-1:0] free_head_ff, free_head_in;

   // slot being moved
   logic [SW-1:0] y_ff, y_in;

   // link store with per-slot written flags
   logic [LW-1:0] link_mem [NS];
   logic [NS-1:0] link_vld_ff;
   logic          link_we;
   logic [SW-1:0] link_waddr;
   logic [LW-1:0] link_wdata;

   logic [SW-1:0] rd_a_addr_in, rd_a_addr_ff, rd_b_addr_ff;
   logic [LW-1:0] rd_a_raw_ff, rd_b_raw_ff, rd_a, rd_b;
   logic          rd_a_vld_ff, rd_b_vld_ff;
   logic          rd_en;

   // data store
   logic [DW-1:0] data_mem [NS];
   logic [DW-1:0] data_rd_ff;
   logic          data_we;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [allfl_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [DW-1:0]                  rsp_value_ff;
   logic [allfl_pkg::POS_W-1:0]    rsp_slot_ff;
   logic                           rsp_empty_ff, rsp_full_ff;
   logic                           done;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_tuser[0];
         at_head_ff <= req_tuser[1];
         pos_ff     <= SW'(req_tdata[allfl_pkg::POS_W-1:0]);
         val_ff     <= req_tdata[allfl_pkg::POS_W +: DW];
      end
   end

   assign rd_a = rd_a_vld_ff ? rd_a_raw_ff : allfl_pkg::reset_link(rd_a_addr_ff);
   assign rd_b = rd_b_vld_ff ? rd_b_raw_ff : allfl_pkg::reset_link(rd_b_addr_ff);

   always_comb begin
      rd_en        = cmd.rd_first || cmd.rd_second;
      rd_a_addr_in = rd_a[SW-1:0];
      y_in         = rd_a[SW-1:0];
      if (cmd.rd_first) begin
         if (op_ff == allfl_pkg::OP_INSERT) begin
            rd_a_addr_in = free_head_ff[SW-1:0];
            y_in         = free_head_ff[SW-1:0];
         end else if (at_head_ff) begin
            rd_a_addr_in = list_head_ff[SW-1:0];
            y_in         = list_head_ff[SW-1:0];
         end else begin
            rd_a_addr_in = pos_ff;
            y_in         = pos_ff;
         end
      end
   end

   always_comb begin
      link_we      = 1'b0;
      link_waddr   = y_ff;
      link_wdata   = free_head_ff;
      data_we      = 1'b0;
      list_head_in = list_head_ff;
      free_head_in = free_head_ff;
      if (cmd.wr_first) begin
         link_we = 1'b1;
         if (op_ff == allfl_pkg::OP_INSERT) begin
            data_we      = 1'b1;
            free_head_in = rd_a;
            if (at_head_ff) begin
               link_wdata   = list_head_ff;
               list_head_in = LW'(y_ff);
            end else begin
               link_wdata = rd_b;
            end
         end else if (at_head_ff) begin
            list_head_in = rd_a;
            free_head_in = LW'(y_ff);
         end else begin
            link_waddr = pos_ff;
            link_wdata = rd_a;
         end
      end else if (cmd.wr_second) begin
         link_we = 1'b1;
         if (op_ff == allfl_pkg::OP_INSERT) begin
            link_waddr = pos_ff;
            link_wdata = LW'(y_ff);
         end else begin
            free_head_in = LW'(y_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (rd_en) begin
         rd_a_raw_ff  <= link_mem[rd_a_addr_in];
         rd_b_raw_ff  <= link_mem[pos_ff];
         rd_a_vld_ff  <= link_vld_ff[rd_a_addr_in];
         rd_b_vld_ff  <= link_vld_ff[pos_ff];
         rd_a_addr_ff <= rd_a_addr_in;
         rd_b_addr_ff <= pos_ff;
         y_ff         <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[y_ff] <= val_ff;
      end
      if (rd_en) begin
         data_rd_ff <= data_mem[y_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff  <= '0;
         list_head_ff <= allfl_pkg::NULL_LINK;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (link_we) begin
            link_vld_ff[link_waddr] <= 1'b1;
         end
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign done         = (cmd.status == allfl_pkg::ST_DONE);
   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.status;
         rsp_value_ff  <= (done && op_ff == allfl_pkg::OP_DELETE) ? data_rd_ff : '0;
         rsp_slot_ff   <= done ? allfl_pkg::POS_W'(y_ff) : '0;
         rsp_empty_ff  <= (list_head_ff == allfl_pkg::NULL_LINK);
         rsp_full_ff   <= (free_head_ff == allfl_pkg::NULL_LINK);
      end
   end

   assign sts.op_insert = (op_ff == allfl_pkg::OP_INSERT);
   assign sts.at_head   = at_head_ff;
   assign sts.free_null = (free_head_ff == allfl_pkg::NULL_LINK);
   assign sts.list_null = (list_head_ff == allfl_pkg::NULL_LINK);
   assign sts.succ_null = (rd_a == allfl_pkg::NULL_LINK);
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_full_ff, rsp_empty_ff, rsp_slot_ff, rsp_value_ff};

endmodule

FILE: sim/tb_array_linked_list_free_list.sv
`timescale 1ns / 1ps
module tb_array_linked_list_free_list;

   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_REQS = 1125;

   localparam int SW  = allfl_pkg::SLOT_W;
   localparam int LW  = allfl_pkg::LINK_W;
   localparam int DW  = allfl_pkg::DATA_WIDTH;
   localparam int NS  = allfl_pkg::LIST_SLOTS;
   localparam int PW  = allfl_pkg::POS_W;
   localparam int STW = allfl_pkg::STATUS_W;

   typedef struct packed {
      logic          op;
      logic          at_head;
      logic [PW-1:0] pos;
      logic [DW-1:0] value;
   } request_type;

   typedef struct packed {
      logic [STW-1:0] status;
      logic [DW-1:0]  value;
      logic [SW-1:0]  slot;
      logic           empty;
      logic           full;
   } outcome_type;

   typedef struct packed {
      request_type req;
      logic        typed;
      outcome_type res;
   } step_row_type;

   // typed results only where they follow directly; the rest go through the predictor
   localparam step_row_type DIR_ROWS [25] = '{
      '{'{allfl_pkg::OP_DELETE, 1'b1, 4'd0,  32'h0000_0000}, 1'b1,
        '{allfl_pkg::ST_EMPTY,   32'h0, 4'd0, 1'b1, 1'b0}},
      '{'{allfl_pkg::OP_DELETE, 1'b0, 4'd15, 32'hFFFF_FFFF}, 1'b1,
        '{allfl_pkg::ST_EMPTY,   32'h0, 4'd0, 1'b1, 1'b0}},
      '{'{allfl_pkg::OP_INSERT, 1'b0, 4'd15, 32'h0000_0000}, 1'b1,
        '{allfl_pkg::ST_DONE,    32'h0, 4'd0, 1'b1, 1'b0}},
      '{'{allfl_pkg::OP_INSERT, 1'b1, 4'd0,  32'hFFFF_FFFF}, 1'b1,
        '{allfl_pkg::ST_DONE,    32'h0, 4'd1, 1'b0, 1'b0}},
      '{'{allfl_pkg::OP_DELETE, 1'b0, 4'd1,  32'h0000_0000}, 1'b1,
        '{allfl_pkg::ST_NO_SUCC, 32'h0, 4'd0, 1'b0, 1'b0}},
      '{'{allfl_pkg::OP_DELETE, 1'b1, 4'd0,  32'h0000_0000}, 1'b1,
        '{allfl_pkg::ST_DONE, 32'hFFFF_FFFF, 4'd1, 1'b1, 1'b0}},
      '{'{allfl_pkg::OP_INSERT, 1'b1, 4'd0,  32'h8000_0000}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b0, 4'd1,  32'h0000_0001}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b1, 4'd0,  32'h7FFF_FFFF}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b0, 4'd2,  32'hA5A5_A5A5}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b0, 4'd3,  32'h5A5A_5A5A}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b1, 4'd0,  32'h1234_5678}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b0, 4'd4,  32'hFFFF_0000}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b0, 4'd7,  32'h0000_FFFF}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b1, 4'd0,  32'hF0F0_F0F0}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b0, 4'd8,  32'h0F0F_0F0F}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b0, 4'd9,  32'hCCCC_CCCC}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b0, 4'd10, 32'h3333_3333}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b1, 4'd0,  32'hC3C3_C3C3}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b0, 4'd12, 32'h3C3C_3C3C}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b0, 4'd14, 32'h9696_9696}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b0, 4'd15, 32'h6969_6969}, 1'b0, '0},
      '{'{allfl_pkg::OP_INSERT, 1'b1, 4'd0,  32'h0000_0000}, 1'b1,
        '{allfl_pkg::ST_FULL,    32'h0, 4'd0, 1'b0, 1'b1}},
      '{'{allfl_pkg::OP_DELETE, 1'b0, 4'd15, 32'h0000_0000}, 1'b0, '0},
      '{'{allfl_pkg::OP_DELETE, 1'b0, 4'd0,  32'h0000_0000}, 1'b1,
        '{allfl_pkg::ST_NO_SUCC, 32'h0, 4'd0, 1'b0, 1'b0}}
   };

   logic                                 clock;
   logic                                 reset      = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [allfl_pkg::REQ_DATA_W-1:0]     req_tdata  = '0;
   logic [allfl_pkg::REQ_USER_W-1:0]     req_tuser  = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [allfl_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic [allfl_pkg::RSP_USER_W-1:0]     rsp_tuser;

   // predictor copy of the pool
   logic [LW-1:0] link_mem [NS];
   logic [DW-1:0] data_mem [NS];
   bit            written  [NS];
   logic [LW-1:0] head_ptr;
   logic [LW-1:0] free_ptr;

   outcome_type pending_outcomes [$];
   outcome_type got_rsp;
   outcome_type want_rsp;
   int          mismatch_count = 0;
   int          idle_cycles    = 0;
   int          req_gap_pct    = 18;
   int          rsp_stall_pct  = 88;

   array_linked_list_free_list u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic flag_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic logic [LW-1:0] follow(input logic [SW-1:0] s);
      return (link_mem[s] >= allfl_pkg::NULL_LINK) ? allfl_pkg::NULL_LINK : link_mem[s];
   endfunction

   function automatic outcome_type apply_list_op(input request_type r);
      outcome_type   o;
      logic [LW-1:0] y;
      o = '0;
      if (r.op == allfl_pkg::OP_INSERT) begin
         if (free_ptr == allfl_pkg::NULL_LINK) begin
            o.status = allfl_pkg::ST_FULL;
         end else begin
            y = free_ptr;
            free_ptr = follow(y[SW-1:0]);
            data_mem[y[SW-1:0]] = r.value;
            written[y[SW-1:0]] = 1'b1;
            if (r.at_head) begin
               link_mem[y[SW-1:0]] = head_ptr;
               head_ptr = y;
            end else begin
               link_mem[y[SW-1:0]] = follow(r.pos);
               link_mem[r.pos] = y;
            end
            o.status = allfl_pkg::ST_DONE;
            o.slot = y[SW-1:0];
         end
      end else if (head_ptr == allfl_pkg::NULL_LINK) begin
         o.status = allfl_pkg::ST_EMPTY;
      end else begin
         if (r.at_head) begin
            y = head_ptr;
            head_ptr = follow(y[SW-1:0]);
         end else begin
            y = follow(r.pos);
            if (y != allfl_pkg::NULL_LINK) link_mem[r.pos] = follow(y[SW-1:0]);
         end
         if (y == allfl_pkg::NULL_LINK) begin
            o.status = allfl_pkg::ST_NO_SUCC;
         end else begin
            o.status = allfl_pkg::ST_DONE;
            o.value = data_mem[y[SW-1:0]];
            o.slot = y[SW-1:0];
            link_mem[y[SW-1:0]] = free_ptr;
            free_ptr = y;
         end
      end
      o.empty = (head_ptr == allfl_pkg::NULL_LINK);
      o.full = (free_ptr == allfl_pkg::NULL_LINK);
      return o;
   endfunction

   // random slot currently reachable from the list head
   function automatic bit pick_member(output logic [SW-1:0] slot);
      logic [SW-1:0] members [NS];
      logic [LW-1:0] p;
      int            n;
      n = 0;
      p = head_ptr;
      while (p != allfl_pkg::NULL_LINK && n < NS) begin
         members[n] = p[SW-1:0];
         n++;
         p = follow(p[SW-1:0]);
      end
      slot = '0;
      if (n == 0) return 1'b0;
      slot = members[$urandom_range(n - 1)];
      return 1'b1;
   endfunction

   task automatic send_request(input request_type r, input bit typed,
                               input outcome_type typed_res);
      outcome_type predicted;
      if ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= allfl_pkg::REQ_DATA_W'({r.value, r.pos});
      req_tuser  <= {r.at_head, r.op};
      do @(posedge clock); while (!req_tready);
      predicted = apply_list_op(r);
      pending_outcomes.push_back(typed ? typed_res : predicted);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_rsp.status = rsp_tuser[STW-1:0];
            got_rsp.value  = rsp_tdata[DW-1:0];
            got_rsp.slot   = rsp_tdata[DW+SW-1:DW];
            got_rsp.empty  = rsp_tdata[DW+SW];
            got_rsp.full   = rsp_tdata[DW+SW+1];
            if (pending_outcomes.size() == 0) begin
               flag_mismatch("response with no request pending");
            end else begin
               want_rsp = pending_outcomes.pop_front();
               if (got_rsp.status != want_rsp.status)
                  flag_mismatch($sformatf("status %0d, want %0d",
                                          got_rsp.status, want_rsp.status));
               if (got_rsp.value != want_rsp.value)
                  flag_mismatch($sformatf("value_out %h, want %h",
                                          got_rsp.value, want_rsp.value));
               if (got_rsp.slot != want_rsp.slot)
                  flag_mismatch($sformatf("slot_used %0d, want %0d",
                                          got_rsp.slot, want_rsp.slot));
               if (got_rsp.empty != want_rsp.empty)
                  flag_mismatch($sformatf("now_empty %0d, want %0d",
                                          got_rsp.empty, want_rsp.empty));
               if (got_rsp.full != want_rsp.full)
                  flag_mismatch($sformatf("now_full %0d, want %0d",
                                          got_rsp.full, want_rsp.full));
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // no progress on either channel for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      request_type   r;
      logic [SW-1:0] member;
      logic [LW-1:0] victim;
      int            k;
      int            bias;
      for (k = 0; k < NS; k++) begin
         link_mem[k] = LW'(k + 1);
         data_mem[k] = '0;
         written[k] = 1'b0;
      end
      head_ptr = allfl_pkg::NULL_LINK;
      free_ptr = '0;
      bias = 50;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < 25; k++)
         send_request(DIR_ROWS[k].req, DIR_ROWS[k].typed, DIR_ROWS[k].res);

      for (k = 0; k < RANDOM_REQS; k++) begin
         if (k == RANDOM_REQS / 3) begin
            req_gap_pct = 88;
            rsp_stall_pct = 18;
         end
         if (k == 2 * RANDOM_REQS / 3) begin
            req_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         // insert-heavy, balanced or delete-heavy runs so both full and empty show up
         if (k % 40 == 0) begin
            case ($urandom_range(2))
               0: bias = 15;
               1: bias = 50;
               default: bias = 85;
            endcase
         end
         r.value = DW'($urandom());
         r.at_head = 1'($urandom_range(1));
         r.pos = PW'($urandom_range(NS - 1));
         if ($urandom_range(99) < 6) begin
            r.op = 1'($urandom_range(1));
         end else begin
            r.op = ($urandom_range(99) < bias) ? allfl_pkg::OP_INSERT : allfl_pkg::OP_DELETE;
            if (pick_member(member)) r.pos = member;
         end
         // never remove a slot whose data word was never stored
         victim = r.at_head ? head_ptr : follow(r.pos);
         if (r.op == allfl_pkg::OP_DELETE && head_ptr != allfl_pkg::NULL_LINK &&
             victim != allfl_pkg::NULL_LINK && !written[victim[SW-1:0]])
            r.op = allfl_pkg::OP_INSERT;
         send_request(r, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
